FILE: hdl/ecgbl_pkg.sv
// Shared widths, register indexes and the sequencer program of the ECG baseline filter.
`default_nettype none

package ecgbl_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int WEIGHT_W    = 16;
	localparam int COEF_W      = 32;
	localparam int BASE_W      = 40;
	localparam int Y_W         = 40;
	localparam int OUT_W       = 32;
	localparam int FRAC_SH     = 28;
	localparam int S_W         = SAMPLE_BITS + 16;
	localparam int X_W         = SAMPLE_BITS + 18;
	localparam int D_W         = BASE_W + 1;
	localparam int V_W         = (X_W > D_W) ? X_W : D_W;
	localparam int LO_W        = 20;
	localparam int HI_W        = V_W - LO_W;
	localparam int MB_W        = (HI_W > LO_W + 1) ? HI_W : LO_W + 1;
	localparam int P_W         = COEF_W + MB_W;
	localparam int ACC_W       = COEF_W + V_W + 3;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 32;
	localparam int N_COEF      = 7;
	localparam int N_HIST      = 4;
	localparam int PC_W        = 5;

	localparam logic [WEIGHT_W-1:0]      WEIGHT_RST = 16'd328;
	localparam logic signed [COEF_W-1:0] B0_RST     = 32'sd912681;
	localparam logic signed [COEF_W-1:0] B2_RST     = -32'sd1825361;
	localparam logic signed [COEF_W-1:0] B4_RST     = 32'sd912681;
	localparam logic signed [COEF_W-1:0] A1_RST     = -32'sd987547199;
	localparam logic signed [COEF_W-1:0] A2_RST     = 32'sd1390415131;
	localparam logic signed [COEF_W-1:0] A3_RST     = -32'sd887393930;
	localparam logic signed [COEF_W-1:0] A4_RST     = 32'sd216358978;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WEIGHT, REG_B0, REG_B2, REG_B4, REG_A1, REG_A2, REG_A3, REG_A4
	} reg_idx_t;

	typedef enum logic [2:0] {
		OP_NOP, OP_LOAD, OP_BASE, OP_XZERO, OP_ROUND, OP_EMIT
	} op_t;

	typedef enum logic [1:0] {
		J_NEXT, J_IN, J_OUT, J_RST
	} jmp_t;

	typedef enum logic [2:0] {
		A_WEIGHT, A_B0, A_B2, A_B4, A_A1, A_A2, A_A3, A_A4
	} a_sel_t;

	typedef enum logic [2:0] {
		B_DIFF, B_X0, B_X2, B_X4, B_Y1, B_Y2, B_Y3, B_Y4
	} b_sel_t;

	typedef struct packed {
		logic mul;
		logic hi;
		logic sub;
		logic clr;
	} mac_ctl_t;

	typedef struct packed {
		op_t      op;
		jmp_t     jmp;
		a_sel_t   a_sel;
		b_sel_t   b_sel;
		mac_ctl_t mac;
	} ucw_t;

	function automatic ucw_t mk(op_t op, jmp_t jmp, a_sel_t a, b_sel_t b,
		logic mul, logic hi, logic sub, logic clr);
		ucw_t w;
		w.op    = op;
		w.jmp   = jmp;
		w.a_sel = a;
		w.b_sel = b;
		w.mac   = '{mul: mul, hi: hi, sub: sub, clr: clr};
		return w;
	endfunction

	// Program: load, baseline product, baseline update, seven split products, round, emit.
	function automatic ucw_t ucode(logic [PC_W-1:0] pc);
		ucw_t w;
		unique case (pc)
			5'd0: w = mk(OP_LOAD, J_IN, A_WEIGHT, B_DIFF, 1'b0, 1'b0, 1'b0, 1'b0);
			5'd1: w = mk(OP_NOP, J_NEXT, A_WEIGHT, B_DIFF, 1'b1, 1'b0, 1'b0, 1'b1);
			5'd2: w = mk(OP_NOP, J_NEXT, A_WEIGHT, B_DIFF, 1'b1, 1'b1, 1'b0, 1'b0);
			5'd3: w = mk(OP_NOP, J_NEXT, A_WEIGHT, B_DIFF, 1'b0, 1'b0, 1'b0, 1'b0);
			5'd4: w = mk(OP_BASE, J_NEXT, A_A1, B_Y1, 1'b1, 1'b0, 1'b1, 1'b1);
			5'd5: w = mk(OP_XZERO, J_NEXT, A_A1, B_Y1, 1'b1, 1'b1, 1'b1, 1'b0);
			5'd6: w = mk(OP_NOP, J_NEXT, A_A2, B_Y2, 1'b1, 1'b0, 1'b1, 1'b0);
			5'd7: w = mk(OP_NOP, J_NEXT, A_A2, B_Y2, 1'b1, 1'b1, 1'b1, 1'b0);
			5'd8: w = mk(OP_NOP, J_NEXT, A_A3, B_Y3, 1'b1, 1'b0, 1'b1, 1'b0);
			5'd9: w = mk(OP_NOP, J_NEXT, A_A3, B_Y3, 1'b1, 1'b1, 1'b1, 1'b0);
			5'd10: w = mk(OP_NOP, J_NEXT, A_A4, B_Y4, 1'b1, 1'b0, 1'b1, 1'b0);
			5'd11: w = mk(OP_NOP, J_NEXT, A_A4, B_Y4, 1'b1, 1'b1, 1'b1, 1'b0);
			5'd12: w = mk(OP_NOP, J_NEXT, A_B2, B_X2, 1'b1, 1'b0, 1'b0, 1'b0);
			5'd13: w = mk(OP_NOP, J_NEXT, A_B2, B_X2, 1'b1, 1'b1, 1'b0, 1'b0);
			5'd14: w = mk(OP_NOP, J_NEXT, A_B4, B_X4, 1'b1, 1'b0, 1'b0, 1'b0);
			5'd15: w = mk(OP_NOP, J_NEXT, A_B4, B_X4, 1'b1, 1'b1, 1'b0, 1'b0);
			5'd16: w = mk(OP_NOP, J_NEXT, A_B0, B_X0, 1'b1, 1'b0, 1'b0, 1'b0);
			5'd17: w = mk(OP_NOP, J_NEXT, A_B0, B_X0, 1'b1, 1'b1, 1'b0, 1'b0);
			5'd18: w = mk(OP_NOP, J_NEXT, A_B0, B_X0, 1'b0, 1'b0, 1'b0, 1'b0);
			5'd19: w = mk(OP_ROUND, J_NEXT, A_B0, B_X0, 1'b0, 1'b0, 1'b0, 1'b0);
			5'd20: w = mk(OP_EMIT, J_OUT, A_B0, B_X0, 1'b0, 1'b0, 1'b0, 1'b0);
			default: w = mk(OP_NOP, J_RST, A_B0, B_X0, 1'b0, 1'b0, 1'b0, 1'b0);
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

FILE: hdl/ecgbl_mac.sv
// Shared multiplier and wide accumulator, one half-width product per step.
`default_nettype none

module ecgbl_mac (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire ecgbl_pkg::mac_ctl_t                  ctl,
	input  wire logic signed [ecgbl_pkg::COEF_W-1:0]  a,
	input  wire logic signed [ecgbl_pkg::V_W-1:0]     v,
	output logic signed [ecgbl_pkg::ACC_W-1:0]        acc
);
	import ecgbl_pkg::*;

	logic signed [MB_W-1:0]  b_op;
	logic signed [P_W-1:0]   prod_s1;
	mac_ctl_t                ctl_s1;
	logic signed [ACC_W-1:0] term;
	logic signed [ACC_W-1:0] acc_q;

	// Low half is unsigned, high half carries the sign
	always_comb begin
		if (ctl.hi) begin
			b_op = MB_W'($signed(v[V_W-1:LO_W]));
		end else begin
			b_op = MB_W'({1'b0, v[LO_W-1:0]});
		end
	end

	always_comb begin
		if (ctl_s1.hi) begin
			term = ACC_W'(prod_s1) <<< LO_W;
		end else begin
			term = ACC_W'(prod_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.mul) begin
			prod_s1 <= a * b_op;
		end
		if (ctl_s1.mul) begin
			priority if (ctl_s1.clr && ctl_s1.sub) begin
				acc_q <= -term;
			end else if (ctl_s1.clr) begin
				acc_q <= term;
			end else if (ctl_s1.sub) begin
				acc_q <= acc_q - term;
			end else begin
				acc_q <= acc_q + term;
			end
		end
	end

	assign acc = acc_q;

endmodule

`default_nettype wire

FILE: hdl/ecg_baseline_iir_filter.sv
// Top level: baseline removal and fourth-order IIR driven by a microcoded sequencer.
//
//   channel          signals                                      dir   width
//   ecg_sample       ecg_sample_valid/_ready, ecg_sample          in    SAMPLE_BITS
//   filtered_sample  filtered_sample_valid/_ready, filtered_sample out  32
//   configuration    cfg_we, cfg_index, cfg_data                  in    3 / 32
//
// The program steps once per cycle, unless it waits for a sample or for a stalled
// emit, through the shared 32-bit multiplier: two steps for each of the eight products
// (41-bit operands are split in halves), plus load, baseline update, rounding and emit.
// The next word is taken only after the result of the last one has been emitted.
// Reset clears the baseline and filter history and restores the default coefficients.
// A result left untaken stalls only the emit step of the following word.
`default_nettype none

module ecg_baseline_iir_filter (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    cfg_we,
	input  wire logic [ecgbl_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [ecgbl_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  wire logic                                    ecg_sample_valid,
	output logic                                         ecg_sample_ready,
	input  wire logic signed [ecgbl_pkg::SAMPLE_BITS-1:0] ecg_sample,
	output logic                                         filtered_sample_valid,
	input  wire logic                                    filtered_sample_ready,
	output logic signed [ecgbl_pkg::OUT_W-1:0]           filtered_sample
);
	import ecgbl_pkg::*;

	localparam int SH_W = ACC_W + 1 - FRAC_SH;
	localparam logic signed [ACC_W:0] HALF = (ACC_W + 1)'(1) <<< (FRAC_SH - 1);

	logic [PC_W-1:0]          pc_q;
	logic [PC_W-1:0]          pc_d;
	ucw_t                     cw;
	logic                     in_acc;
	logic                     emit_go;

	logic [WEIGHT_W-1:0]      weight_q;
	logic signed [COEF_W-1:0] coef_q [N_COEF];
	logic signed [BASE_W-1:0] baseline_q;
	logic signed [S_W-1:0]    s_q;
	logic signed [D_W-1:0]    d_q;
	logic signed [X_W-1:0]    x0_q;
	logic signed [X_W-1:0]    xin_q [N_HIST];
	logic signed [Y_W-1:0]    yout_q [N_HIST];
	logic signed [Y_W-1:0]    y_q;
	logic                     out_valid_q;
	logic signed [OUT_W-1:0]  out_q;

	logic signed [S_W-1:0]    s_in;
	logic signed [D_W-1:0]    d_in;
	logic signed [V_W-1:0]    x_diff;
	logic signed [COEF_W-1:0] a_op;
	logic signed [V_W-1:0]    v_op;
	logic signed [ACC_W-1:0]  acc;
	logic signed [ACC_W:0]    rnd;
	logic signed [SH_W-1:0]   sh;
	logic signed [Y_W-1:0]    y_new;
	logic signed [OUT_W-1:0]  out_new;

	assign cw               = ucode(pc_q);
	assign ecg_sample_ready = (cw.jmp == J_IN);
	assign in_acc           = ecg_sample_valid && ecg_sample_ready;
	assign emit_go          = (cw.op == OP_EMIT) && (!out_valid_q || filtered_sample_ready);

	always_comb begin
		unique case (cw.jmp)
			J_NEXT: pc_d = pc_q + PC_W'(1);
			J_IN:   pc_d = in_acc ? pc_q + PC_W'(1) : pc_q;
			J_OUT:  pc_d = emit_go ? '0 : pc_q;
			J_RST:  pc_d = '0;
			default: pc_d = '0;
		endcase
	end

	assign s_in   = {ecg_sample, 16'b0};
	assign d_in   = D_W'(s_in) - D_W'(baseline_q);
	assign x_diff = V_W'(s_q) - V_W'(baseline_q);

	always_comb begin
		unique case (cw.a_sel)
			A_WEIGHT: a_op = COEF_W'({1'b0, weight_q});
			A_B0:     a_op = coef_q[0];
			A_B2:     a_op = coef_q[1];
			A_B4:     a_op = coef_q[2];
			A_A1:     a_op = coef_q[3];
			A_A2:     a_op = coef_q[4];
			A_A3:     a_op = coef_q[5];
			A_A4:     a_op = coef_q[6];
			default:  a_op = '0;
		endcase
	end

	always_comb begin
		unique case (cw.b_sel)
			B_DIFF:  v_op = V_W'(d_q);
			B_X0:    v_op = V_W'(x0_q);
			B_X2:    v_op = V_W'(xin_q[1]);
			B_X4:    v_op = V_W'(xin_q[3]);
			B_Y1:    v_op = V_W'(yout_q[0]);
			B_Y2:    v_op = V_W'(yout_q[1]);
			B_Y3:    v_op = V_W'(yout_q[2]);
			B_Y4:    v_op = V_W'(yout_q[3]);
			default: v_op = '0;
		endcase
	end

	ecgbl_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (cw.mac),
		.a      (a_op),
		.v      (v_op),
		.acc    (acc)
	);

	// Round half up, drop the fraction, clamp to the feedback width
	assign rnd = (ACC_W + 1)'(acc) + HALF;
	assign sh  = rnd[ACC_W:FRAC_SH];

	always_comb begin
		if ((&sh[SH_W-1:Y_W-1]) || !(|sh[SH_W-1:Y_W-1])) begin
			y_new = sh[Y_W-1:0];
		end else if (sh[SH_W-1]) begin
			y_new = {1'b1, {(Y_W - 1){1'b0}}};
		end else begin
			y_new = {1'b0, {(Y_W - 1){1'b1}}};
		end
	end

	always_comb begin
		if ((&y_q[Y_W-1:OUT_W-1]) || !(|y_q[Y_W-1:OUT_W-1])) begin
			out_new = y_q[OUT_W-1:0];
		end else if (y_q[Y_W-1]) begin
			out_new = {1'b1, {(OUT_W - 1){1'b0}}};
		end else begin
			out_new = {1'b0, {(OUT_W - 1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			pc_q <= pc_d;
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (filtered_sample_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q   <= WEIGHT_RST;
			coef_q[0]  <= B0_RST;
			coef_q[1]  <= B2_RST;
			coef_q[2]  <= B4_RST;
			coef_q[3]  <= A1_RST;
			coef_q[4]  <= A2_RST;
			coef_q[5]  <= A3_RST;
			coef_q[6]  <= A4_RST;
			baseline_q <= '0;
			for (int i = 0; i < N_HIST; i++) begin
				xin_q[i]  <= '0;
				yout_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_WEIGHT: weight_q  <= cfg_data[WEIGHT_W-1:0];
					REG_B0:     coef_q[0] <= cfg_data[COEF_W-1:0];
					REG_B2:     coef_q[1] <= cfg_data[COEF_W-1:0];
					REG_B4:     coef_q[2] <= cfg_data[COEF_W-1:0];
					REG_A1:     coef_q[3] <= cfg_data[COEF_W-1:0];
					REG_A2:     coef_q[4] <= cfg_data[COEF_W-1:0];
					REG_A3:     coef_q[5] <= cfg_data[COEF_W-1:0];
					REG_A4:     coef_q[6] <= cfg_data[COEF_W-1:0];
					default:    weight_q  <= weight_q;
				endcase
			end
			if (cw.op == OP_BASE) begin
				// floor shift of the weighted difference
				baseline_q <= baseline_q + acc[BASE_W+WEIGHT_W-1:WEIGHT_W];
			end
			if (emit_go) begin
				for (int i = N_HIST - 1; i > 0; i--) begin
					xin_q[i]  <= xin_q[i-1];
					yout_q[i] <= yout_q[i-1];
				end
				xin_q[0]  <= x0_q;
				yout_q[0] <= y_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			s_q <= s_in;
			d_q <= d_in;
		end
		if (cw.op == OP_XZERO) begin
			x0_q <= x_diff[X_W-1:0];
		end
		if (cw.op == OP_ROUND) begin
			y_q <= y_new;
		end
		if (emit_go) begin
			out_q <= out_new;
		end
	end

	assign filtered_sample_valid = out_valid_q;
	assign filtered_sample       = out_q;

endmodule

`default_nettype wire
